@@ rtl/sync_word_packet_deframer_top_assert.svh @@
// Assertion macros for the deframer, clocked on clock; only the never check is qualified by reset.
`ifndef SYNC_WORD_PACKET_DEFRAMER_TOP_ASSERT_SVH
`define SYNC_WORD_PACKET_DEFRAMER_TOP_ASSERT_SVH

// cond must never hold outside reset
`define SWPD_ASSERT_NEVER(lbl, cond, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) !(cond)) else $error(msg);

// trig in one cycle implies res in the next, also across reset
`define SWPD_ASSERT_NEXT(lbl, trig, res, msg) \
   lbl: assert property (@(posedge clock) (trig) |=> (res)) else $error(msg);

`endif

@@ rtl/swpd_pkg.sv @@
package swpd_pkg;

   localparam int FRAME_BYTES = 64;
   localparam int IDX_W       = (FRAME_BYTES > 2) ? $clog2(FRAME_BYTES) : 1;
   localparam int FILL_W      = $clog2(FRAME_BYTES + 1);
   localparam int ADDR_W      = IDX_W + 1;
   localparam int RAM_DEPTH   = 2 ** ADDR_W;

   localparam logic [7:0]  SYNC_FIRST    = 8'h55;
   localparam logic [7:0]  SYNC_SECOND   = 8'hAA;
   localparam logic [15:0] TIMEOUT_RESET = 16'd1000;
   localparam logic [15:0] IDLE_MAX      = 16'hFFFF;

   typedef enum logic {
      OP_BYTE = 1'b0,
      OP_TICK = 1'b1
   } opcode_type;

   typedef enum logic {
      KIND_GOOD = 1'b0,
      KIND_FAIL = 1'b1
   } kind_type;

   typedef struct packed {
      kind_type   kind;
      logic       bank;
      logic [7:0] rx_byte;
      logic [7:0] xor_val;
   } job_type;

   typedef struct packed {
      logic valid;
      logic bank;
   } bank_free_type;

   typedef struct packed {
      logic [1:0] bank_busy;
   } front_status_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic [7:0] computed_xor;
      kind_type   kind;
      logic       last;
   } result_type;

endpackage

@@ rtl/sync_word_packet_deframer_top.sv @@
// Input: one transaction per cycle; a tick or byte is absorbed in the cycle it is taken.
// The frame store is double banked: the input stalls only while both banks hold frames
// waiting for readout, or the two-entry job queue is full.
// A frame's job passes job queue, job register and read stage; a good frame streams one byte
// per cycle from the registered store read port unless stalled; a failure report is one item.
// Reset (synchronous, active high) clears control state and loads timeout 1000; no store clear.
`include "sync_word_packet_deframer_top_assert.svh"

module sync_word_packet_deframer_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   input  logic        req_opcode,
   input  logic [7:0]  req_rx_byte,
   output logic        full,
   input  logic        csr_wr_en,
   input  logic [15:0] csr_wr_data,
   input  logic        pop,
   output logic        empty,
   output logic [7:0]  rsp_out_byte,
   output logic [7:0]  rsp_computed_xor,
   output logic        rsp_report_kind,
   output logic        rsp_last
);
   import swpd_pkg::*;

   logic             jq_push, jq_full, jq_pop, jq_empty;
   job_type          jq_wdata, jq_rdata;
   bank_free_type    bank_free;
   front_status_type status;
   logic             ram_wr_en, ram_rd_en;
   logic [ADDR_W-1:0] ram_wr_addr, ram_rd_addr;
   logic [7:0]       ram_wr_data, ram_rd_data;

   swpd_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_push    (push),
      .req_opcode  (req_opcode),
      .req_rx_byte (req_rx_byte),
      .req_full    (full),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .jq_push     (jq_push),
      .jq_data     (jq_wdata),
      .jq_full     (jq_full),
      .bank_free   (bank_free),
      .status      (status),
      .ram_wr_en   (ram_wr_en),
      .ram_wr_addr (ram_wr_addr),
      .ram_wr_data (ram_wr_data)
   );

   swpd_job_queue u_job_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (jq_push),
      .push_data (jq_wdata),
      .full      (jq_full),
      .pop       (jq_pop),
      .pop_data  (jq_rdata),
      .empty     (jq_empty)
   );

   swpd_ram #(
      .WIDTH (8),
      .DEPTH (RAM_DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   swpd_back u_back (
      .clock            (clock),
      .reset            (reset),
      .jq_empty         (jq_empty),
      .jq_data          (jq_rdata),
      .jq_pop           (jq_pop),
      .bank_free        (bank_free),
      .ram_rd_en        (ram_rd_en),
      .ram_rd_addr      (ram_rd_addr),
      .ram_rd_data      (ram_rd_data),
      .rsp_pop          (pop),
      .rsp_empty        (empty),
      .rsp_out_byte     (rsp_out_byte),
      .rsp_computed_xor (rsp_computed_xor),
      .rsp_report_kind  (rsp_report_kind),
      .rsp_last         (rsp_last)
   );

   `SWPD_ASSERT_NEVER(a_no_push_when_full, jq_push && jq_full, "job pushed into full queue")
   `SWPD_ASSERT_NEVER(a_free_busy_bank,
      bank_free.valid && !status.bank_busy[bank_free.bank], "freed a bank that was not busy")
   `SWPD_ASSERT_NEXT(a_reset_clean, reset, empty && !full, "not idle after reset")

endmodule

@@ rtl/swpd_ram.sv @@
module swpd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 128
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/swpd_job_queue.sv @@
module swpd_job_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  swpd_pkg::job_type push_data,
   output logic             full,
   input  logic             pop,
   output swpd_pkg::job_type pop_data,
   output logic             empty
);
   import swpd_pkg::*;

   job_type    entry_ff [2];
   logic       wp_ff, wp_in;
   logic       rp_ff, rp_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       do_push, do_pop;

   always_comb begin
      do_push = push && (cnt_ff != 2'd2);
      do_pop  = pop && (cnt_ff != 2'd0);
      wp_in   = do_push ? ~wp_ff : wp_ff;
      rp_in   = do_pop ? ~rp_ff : rp_ff;
      cnt_in  = cnt_ff + 2'(do_push) - 2'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= 1'b0;
         rp_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wp_ff] <= push_data;
      end
   end

   assign full     = (cnt_ff == 2'd2);
   assign empty    = (cnt_ff == 2'd0);
   assign pop_data = entry_ff[rp_ff];

endmodule

@@ rtl/swpd_front.sv @@
module swpd_front (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_push,
   input  logic                       req_opcode,
   input  logic [7:0]                 req_rx_byte,
   output logic                       req_full,
   input  logic                       csr_wr_en,
   input  logic [15:0]                csr_wr_data,
   output logic                       jq_push,
   output swpd_pkg::job_type          jq_data,
   input  logic                       jq_full,
   input  swpd_pkg::bank_free_type    bank_free,
   output swpd_pkg::front_status_type status,
   output logic                       ram_wr_en,
   output logic [swpd_pkg::ADDR_W-1:0] ram_wr_addr,
   output logic [7:0]                 ram_wr_data
);
   import swpd_pkg::*;

   logic [FILL_W-1:0] fill_ff, fill_in;
   logic [7:0]        xor_ff, xor_in;
   logic [15:0]       idle_ff, idle_in;
   logic [15:0]       timeout_ff, timeout_in;
   logic              wr_bank_ff, wr_bank_in;
   logic [1:0]        busy_ff, busy_in;

   logic              accept;
   logic [15:0]       idle_sat;
   logic [FILL_W-1:0] fill_next;
   logic [IDX_W-1:0]  wr_idx;
   logic [1:0]        set_mask, clr_mask;

   assign req_full = jq_full || busy_ff[wr_bank_ff];
   assign accept   = req_push && !req_full;

   always_comb begin
      fill_in     = fill_ff;
      xor_in      = xor_ff;
      idle_in     = idle_ff;
      wr_bank_in  = wr_bank_ff;
      timeout_in  = csr_wr_en ? csr_wr_data : timeout_ff;
      set_mask    = 2'b00;
      clr_mask    = bank_free.valid ? (2'b01 << bank_free.bank) : 2'b00;
      idle_sat    = (idle_ff == IDLE_MAX) ? idle_ff : idle_ff + 16'd1;
      fill_next   = fill_ff + FILL_W'(1);
      wr_idx      = fill_ff[IDX_W-1:0];
      ram_wr_en   = 1'b0;
      jq_push     = 1'b0;
      jq_data.kind    = KIND_GOOD;
      jq_data.bank    = wr_bank_ff;
      jq_data.rx_byte = req_rx_byte;
      jq_data.xor_val = xor_ff;

      if (accept) begin
         if (req_opcode == OP_TICK) begin
            if (fill_ff != '0) begin
               if (idle_sat > timeout_ff) begin
                  fill_in = '0;
                  xor_in  = 8'h00;
                  idle_in = 16'd0;
               end else begin
                  idle_in = idle_sat;
               end
            end
         end else begin
            idle_in = 16'd0;
            if (fill_ff == '0) begin
               if (req_rx_byte == SYNC_FIRST) begin
                  ram_wr_en = 1'b1;
                  xor_in    = req_rx_byte;
                  fill_in   = FILL_W'(1);
               end
            end else if (fill_ff == FILL_W'(1)) begin
               if (req_rx_byte == SYNC_SECOND) begin
                  ram_wr_en = 1'b1;
                  xor_in    = xor_ff ^ req_rx_byte;
                  fill_in   = FILL_W'(2);
               end else begin
                  fill_in = '0;
                  xor_in  = 8'h00;
               end
            end else begin
               ram_wr_en = 1'b1;
               if (fill_next >= FILL_W'(FRAME_BYTES)) begin
                  jq_push = 1'b1;
                  if (xor_ff == req_rx_byte) begin
                     wr_bank_in = ~wr_bank_ff;
                     set_mask   = 2'b01 << wr_bank_ff;
                  end else begin
                     jq_data.kind = KIND_FAIL;
                  end
                  fill_in = '0;
                  xor_in  = 8'h00;
               end else begin
                  fill_in = fill_next;
                  xor_in  = xor_ff ^ req_rx_byte;
               end
            end
         end
      end
      busy_in = (busy_ff | set_mask) & ~clr_mask;
   end

   assign ram_wr_addr   = {wr_bank_ff, wr_idx};
   assign ram_wr_data   = req_rx_byte;
   assign status.bank_busy = busy_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff    <= '0;
         xor_ff     <= 8'h00;
         idle_ff    <= 16'd0;
         timeout_ff <= TIMEOUT_RESET;
         wr_bank_ff <= 1'b0;
         busy_ff    <= 2'b00;
      end else begin
         fill_ff    <= fill_in;
         xor_ff     <= xor_in;
         idle_ff    <= idle_in;
         timeout_ff <= timeout_in;
         wr_bank_ff <= wr_bank_in;
         busy_ff    <= busy_in;
      end
   end

endmodule

@@ rtl/swpd_back.sv @@
module swpd_back (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        jq_empty,
   input  swpd_pkg::job_type           jq_data,
   output logic                        jq_pop,
   output swpd_pkg::bank_free_type     bank_free,
   output logic                        ram_rd_en,
   output logic [swpd_pkg::ADDR_W-1:0] ram_rd_addr,
   input  logic [7:0]                  ram_rd_data,
   input  logic                        rsp_pop,
   output logic                        rsp_empty,
   output logic [7:0]                  rsp_out_byte,
   output logic [7:0]                  rsp_computed_xor,
   output logic                        rsp_report_kind,
   output logic                        rsp_last
);
   import swpd_pkg::*;

   logic             active_ff, active_in;
   job_type          job_ff;
   logic [IDX_W-1:0] k_ff, k_in;
   logic             s1_valid_ff;
   kind_type         s1_kind_ff;
   logic             s1_last_ff;
   logic [7:0]       s1_byte_ff;
   logic [7:0]       s1_xor_ff;
   result_type       fifo_ff [2];
   logic             wp_ff, rp_ff;
   logic [1:0]       cnt_ff, cnt_in;

   logic             pop_out, issue, k_last, is_fail;
   logic [2:0]       occ;
   result_type       wr_res, head;

   always_comb begin
      pop_out = rsp_pop && (cnt_ff != 2'd0);
      // room for one more transaction once the staged one has landed
      occ     = 3'(cnt_ff) + 3'(s1_valid_ff) - 3'(pop_out);
      is_fail = (job_ff.kind == KIND_FAIL);
      k_last  = (k_ff == IDX_W'(FRAME_BYTES - 1));
      jq_pop  = !active_ff && !jq_empty;
      issue   = active_ff && (occ < 3'd2);

      active_in = active_ff;
      k_in      = k_ff;
      if (jq_pop) begin
         active_in = 1'b1;
         k_in      = '0;
      end else if (issue) begin
         k_in = k_ff + IDX_W'(1);
         if (is_fail || k_last) begin
            active_in = 1'b0;
         end
      end

      cnt_in = cnt_ff + 2'(s1_valid_ff) - 2'(pop_out);

      wr_res.kind         = s1_kind_ff;
      wr_res.last         = s1_last_ff;
      wr_res.out_byte     = (s1_kind_ff == KIND_FAIL) ? s1_byte_ff : ram_rd_data;
      wr_res.computed_xor = (s1_kind_ff == KIND_FAIL) ? s1_xor_ff : 8'h00;
   end

   assign ram_rd_en       = issue && !is_fail;
   assign ram_rd_addr     = {job_ff.bank, k_ff};
   assign bank_free.valid = issue && !is_fail && k_last;
   assign bank_free.bank  = job_ff.bank;

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff   <= 1'b0;
         s1_valid_ff <= 1'b0;
         wp_ff       <= 1'b0;
         rp_ff       <= 1'b0;
         cnt_ff      <= 2'd0;
      end else begin
         active_ff   <= active_in;
         s1_valid_ff <= issue;
         wp_ff       <= s1_valid_ff ? ~wp_ff : wp_ff;
         rp_ff       <= pop_out ? ~rp_ff : rp_ff;
         cnt_ff      <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      k_ff <= k_in;
      if (jq_pop) begin
         job_ff <= jq_data;
      end
      if (issue) begin
         s1_kind_ff <= job_ff.kind;
         s1_last_ff <= is_fail || k_last;
         s1_byte_ff <= job_ff.rx_byte;
         s1_xor_ff  <= job_ff.xor_val;
      end
      if (s1_valid_ff) begin
         fifo_ff[wp_ff] <= wr_res;
      end
   end

   assign head             = fifo_ff[rp_ff];
   assign rsp_empty        = (cnt_ff == 2'd0);
   assign rsp_out_byte     = head.out_byte;
   assign rsp_computed_xor = head.computed_xor;
   assign rsp_report_kind  = head.kind;
   assign rsp_last         = head.last;

endmodule
